// ----- hw/rtl/mhd_conserved_to_primitive_defines.svh -----
// Assertion macros used by the checker file.
// No dependencies; expects a clk and rst in the including scope.
`ifndef MHD_CONSERVED_TO_PRIMITIVE_DEFINES_SVH
`define MHD_CONSERVED_TO_PRIMITIVE_DEFINES_SVH

// next-cycle implication, off during reset
`define MHDC2P_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mhdc2p assertion failed");

// same-cycle implication, off during reset
`define MHDC2P_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mhdc2p assertion failed");

// next-cycle implication, active during reset
`define MHDC2P_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mhdc2p assertion failed");

`endif

// ----- hw/rtl/mhdc2p_pkg.sv -----
// Shared constants, types, divider step and velocity saturation functions for the MHD primitive converter.
// No dependencies.
package mhdc2p_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int CW         = 31;
  localparam int NUM_W      = 64;
  localparam int DIV_W      = 33;
  localparam int DIV_STAGES = NUM_W;
  localparam int NDIV       = 5;
  localparam int PB_W       = NUM_W - (FRAC_BITS + 1);
  localparam int PRAW_W     = 2 * CW - FRAC_BITS;
  localparam int NCORE      = DIV_STAGES + 5;

  localparam int LANE_VX = 0;
  localparam int LANE_VY = 1;
  localparam int LANE_VZ = 2;
  localparam int LANE_EK = 3;
  localparam int LANE_PF = 4;

  localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    REG_GAMMA  = 2'd0,
    REG_DFLOOR = 2'd1,
    REG_PFLOOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_W-1:0] n;
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] dv;
  } div_lane_t;

  typedef struct packed {
    logic [CW-1:0]        d;
    logic signed [DW-1:0] bx;
    logic signed [DW-1:0] by;
    logic signed [DW-1:0] bz;
    logic signed [DW-1:0] ein;
    logic [2:0]           msign;
    logic [PB_W-1:0]      pb;
  } side_t;

  // one restoring quotient bit; quotient shifts into n from the bottom
  function automatic div_lane_t div_step(input div_lane_t a);
    div_lane_t      o;
    logic [DIV_W:0] t;
    o = a;
    t = {a.r, a.n[NUM_W-1]};
    if (t >= {1'b0, a.dv}) begin
      t   = t - {1'b0, a.dv};
      o.n = {a.n[NUM_W-2:0], 1'b1};
    end else begin
      o.n = {a.n[NUM_W-2:0], 1'b0};
    end
    o.r = t[DIV_W-1:0];
    return o;
  endfunction

  function automatic logic signed [DW-1:0] sat_vel(input logic [NUM_W-1:0] q, input logic neg);
    logic signed [DW-1:0] v;
    if (neg) begin
      if (q > NUM_W'(64'h8000_0000)) v = {1'b1, {(DW-1){1'b0}}};
      else                           v = -$signed(q[DW-1:0]);
    end else begin
      if (q > NUM_W'(64'h7FFF_FFFF)) v = {1'b0, {(DW-1){1'b1}}};
      else                           v = $signed(q[DW-1:0]);
    end
    return v;
  endfunction

endpackage

// ----- hw/rtl/mhd_conserved_to_primitive.sv -----
// Conserved-to-primitive conversion for adiabatic MHD cells, Q16.16 fixed point.
// Uses mhdc2p_pkg.
//
// One cell is accepted per clock cycle unless an output stall holds the pipe;
// the depth is set by the 64-step pipelined restoring dividers (three
// velocities, kinetic energy, energy correction), with three stages ahead of
// them (density floor and face averaging, squares, sums) and two after
// (pressure difference, gamma multiply) plus the output register.
// Stalls on the output hold the whole pipe, except that a new request is still
// taken while a result waits if the stage before the output is empty.
// Configuration writes are always ready and must only be made while idle.
module mhd_conserved_to_primitive import mhdc2p_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] density_in,
  input  logic signed [DW-1:0] momentum_x,
  input  logic signed [DW-1:0] momentum_y,
  input  logic signed [DW-1:0] momentum_z,
  input  logic signed [DW-1:0] energy_in,
  input  logic signed [DW-1:0] field_x_lower,
  input  logic signed [DW-1:0] field_x_upper,
  input  logic signed [DW-1:0] field_y_lower,
  input  logic signed [DW-1:0] field_y_upper,
  input  logic signed [DW-1:0] field_z_lower,
  input  logic signed [DW-1:0] field_z_upper,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CW-1:0]        density_out,
  output logic signed [DW-1:0] velocity_x,
  output logic signed [DW-1:0] velocity_y,
  output logic signed [DW-1:0] velocity_z,
  output logic [CW-1:0]        pressure,
  output logic signed [DW-1:0] center_field_x,
  output logic signed [DW-1:0] center_field_y,
  output logic signed [DW-1:0] center_field_z,
  output logic signed [DW-1:0] energy_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  logic [CW-1:0] gamma_minus_one, dens_min, pres_min;
  logic [NCORE-1:0] v;
  logic en, out_free;

  // stage A
  logic [DW-1:0]        am [3];
  logic [DW-1:0]        abm [3];
  logic signed [DW-1:0] ab [3];
  logic [2:0]           asign;
  logic [CW-1:0]        ad, adiv;
  logic signed [DW-1:0] aein;
  // stage B
  logic [NUM_W-1:0]     msq [3];
  logic [NUM_W-1:0]     bsq [3];
  logic [DW-1:0]        bm [3];
  logic signed [DW-1:0] bb [3];
  logic [2:0]           bsign;
  logic [CW-1:0]        bd, bdiv;
  logic signed [DW-1:0] bein;
  // divider pipe, index 0 is the load stage
  div_lane_t lane [DIV_STAGES+1][NDIV];
  side_t     side [DIV_STAGES+1];
  // stage E1 and E2
  logic signed [DW-1:0] e1vel [3];
  logic [CW-1:0]        e1dpos, e1tsat;
  side_t                e1side;
  logic signed [DW-1:0] e2vel [3];
  logic [2*CW-1:0]      e2prod;
  logic [CW-1:0]        e2tsat;
  side_t                e2side;

  logic signed [DW:0]   fsum [3];
  logic signed [DW-1:0] flo [3];
  logic signed [DW-1:0] fup [3];
  logic signed [DW-1:0] mom [3];
  logic signed [DW-1:0] avg [3];
  logic [CW-1:0]        d_sel;
  logic [NUM_W-1:0]     sm, sb;
  logic [NUM_W-1:0]     qv [3];
  logic [NUM_W-1:0]     ek, qpf;
  logic signed [NUM_W+1:0] diff;
  logic [NUM_W:0]       tsum;
  logic [PRAW_W-1:0]    praw;
  logic                 floored;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign en        = out_free || !v[NCORE-1];
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_minus_one <= CW'(43691);
      dens_min        <= CW'(1);
      pres_min        <= CW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAMMA:  gamma_minus_one <= cfg_data;
        REG_DFLOOR: dens_min        <= cfg_data;
        REG_PFLOOR: pres_min        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en) v <= {v[NCORE-2:0], in_valid};
      if (out_free) out_valid <= v[NCORE-1];
    end
  end

  // stage A: floor, face averages, magnitudes
  always_comb begin
    flo = '{field_x_lower, field_y_lower, field_z_lower};
    fup = '{field_x_upper, field_y_upper, field_z_upper};
    mom = '{momentum_x, momentum_y, momentum_z};
    for (int i = 0; i < 3; i++) begin
      fsum[i] = (DW+1)'(flo[i]) + (DW+1)'(fup[i]);
      avg[i]  = fsum[i][DW:1];
    end
    if (density_in > $signed({1'b0, dens_min})) d_sel = density_in[CW-1:0];
    else                                        d_sel = dens_min;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        am[i]    <= mom[i][DW-1] ? DW'(-mom[i]) : DW'(mom[i]);
        asign[i] <= mom[i][DW-1];
        ab[i]    <= avg[i];
        abm[i]   <= avg[i][DW-1] ? DW'(-avg[i]) : DW'(avg[i]);
      end
      ad   <= d_sel;
      adiv <= (d_sel == '0) ? CW'(1) : d_sel;
      aein <= energy_in;
    end
  end

  // stage B: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        msq[i] <= NUM_W'(am[i]) * NUM_W'(am[i]);
        bsq[i] <= NUM_W'(abm[i]) * NUM_W'(abm[i]);
        bm[i]  <= am[i];
        bb[i]  <= ab[i];
      end
      bsign <= asign;
      bd    <= ad;
      bdiv  <= adiv;
      bein  <= aein;
    end
  end

  // stage C: sums and divider load, then the divider steps
  assign sm = msq[0] + msq[1] + msq[2];
  assign sb = bsq[0] + bsq[1] + bsq[2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        lane[0][i].n  <= NUM_W'(bm[i]) << FRAC_BITS;
        lane[0][i].r  <= '0;
        lane[0][i].dv <= DIV_W'(bdiv);
      end
      lane[0][LANE_EK].n  <= sm;
      lane[0][LANE_EK].r  <= '0;
      lane[0][LANE_EK].dv <= {1'b0, bdiv, 1'b0};
      lane[0][LANE_PF].n  <= NUM_W'(pres_min) << FRAC_BITS;
      lane[0][LANE_PF].r  <= '0;
      lane[0][LANE_PF].dv <= (gamma_minus_one == '0) ? DIV_W'(1) : DIV_W'(gamma_minus_one);
      side[0].d     <= bd;
      side[0].bx    <= bb[0];
      side[0].by    <= bb[1];
      side[0].bz    <= bb[2];
      side[0].ein   <= bein;
      side[0].msign <= bsign;
      side[0].pb    <= sb[NUM_W-1:FRAC_BITS+1];
      for (int k = 1; k <= DIV_STAGES; k++) begin
        for (int j = 0; j < NDIV; j++) lane[k][j] <= div_step(lane[k-1][j]);
        side[k] <= side[k-1];
      end
    end
  end

  // stage E1: saturate velocities, pressure difference, corrected energy
  always_comb begin
    for (int i = 0; i < 3; i++) qv[i] = lane[DIV_STAGES][i].n;
    ek   = lane[DIV_STAGES][LANE_EK].n;
    qpf  = lane[DIV_STAGES][LANE_PF].n;
    diff = (NUM_W+2)'(side[DIV_STAGES].ein) - $signed({2'b0, ek})
         - $signed({{(NUM_W+2-PB_W){1'b0}}, side[DIV_STAGES].pb});
    tsum = (NUM_W+1)'(qpf) + (NUM_W+1)'(ek) + (NUM_W+1)'(side[DIV_STAGES].pb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) e1vel[i] <= sat_vel(qv[i], side[DIV_STAGES].msign[i]);
      e1dpos <= (diff > 0) ? diff[CW-1:0] : '0;
      e1tsat <= (tsum > (NUM_W+1)'(CFG_MAX)) ? CFG_MAX : tsum[CW-1:0];
      e1side <= side[DIV_STAGES];
    end
  end

  // stage E2: gamma multiply
  always_ff @(posedge clk) begin
    if (en) begin
      e2prod <= (2*CW)'(gamma_minus_one) * (2*CW)'(e1dpos);
      e2vel  <= e1vel;
      e2tsat <= e1tsat;
      e2side <= e1side;
    end
  end

  // output register: pressure floor and select
  assign praw    = e2prod[2*CW-1:FRAC_BITS];
  assign floored = !(praw > PRAW_W'(pres_min));

  always_ff @(posedge clk) begin
    if (out_free) begin
      density_out    <= e2side.d;
      velocity_x     <= e2vel[0];
      velocity_y     <= e2vel[1];
      velocity_z     <= e2vel[2];
      center_field_x <= e2side.bx;
      center_field_y <= e2side.by;
      center_field_z <= e2side.bz;
      if (floored) begin
        pressure   <= pres_min;
        energy_out <= $signed({1'b0, e2tsat});
      end else begin
        pressure   <= (praw > PRAW_W'(CFG_MAX)) ? CFG_MAX : praw[CW-1:0];
        energy_out <= e2side.ein;
      end
    end
  end

endmodule

// ----- hw/rtl/mhdc2p_checker.sv -----
// Port-level checks for the MHD primitive converter, bound to the top level.
// Uses mhdc2p_pkg and mhd_conserved_to_primitive_defines.svh.
`include "mhd_conserved_to_primitive_defines.svh"

module mhdc2p_checker import mhdc2p_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [DW-1:0] velocity_x,
  input logic [CW-1:0]        pressure,
  input logic signed [DW-1:0] energy_out
);

  logic [6:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 7'(in_valid && in_ready) - 7'(out_valid && out_ready);
    end
  end

  `MHDC2P_ASSERT_RST(a_reset_idle, rst, !out_valid)
  `MHDC2P_ASSERT_NOW(a_no_orphan, out_valid, pending != '0)
  `MHDC2P_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `MHDC2P_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(velocity_x) && $stable(pressure) && $stable(energy_out))

endmodule

bind mhd_conserved_to_primitive mhdc2p_checker u_mhdc2p_checker (.*);
